// File: rtl/pcu_pkg.sv
`timescale 1ns / 1ps

package pcu_pkg;

    // index and result field widths
    localparam int INDEX_W   = 64;
    localparam int SQ_W      = 6;
    localparam int CODE_W    = 2;

    // C(x,k) for x <= 64, k <= 8 stays below 2^33
    localparam int BINOM_W   = 33;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int SQC_W      = 7;
    localparam int PCC_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIECE_COUNT  = 1'b1;

    localparam logic [SQC_W-1:0] SQUARE_COUNT_RST = 7'd50;
    localparam logic [PCC_W-1:0] PIECE_COUNT_RST  = 4'd4;

    // table fill status toward the sequencer
    typedef struct packed {
        logic wr_en;
        logic done;
    } t_fill_status;

endpackage

// File: rtl/pcu_ram.sv
`timescale 1ns / 1ps

module pcu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pcu_pascal_fill.sv
`timescale 1ns / 1ps

module pcu_pascal_fill #(
    parameter int MAX_PIECES  = 8,
    parameter int MAX_SQUARES = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    output pcu_pkg::t_fill_status                     o_status,
    output logic [$clog2(MAX_SQUARES+1)-1:0]          o_waddr,
    output logic [MAX_PIECES*pcu_pkg::BINOM_W-1:0]    o_wdata
);

    import pcu_pkg::*;

    localparam int AW = $clog2(MAX_SQUARES + 1);

    // r_row[k] holds C(x, k+1) for the row x = r_cnt while the fill runs
    logic [BINOM_W-1:0] r_row [MAX_PIECES];
    logic [BINOM_W-1:0] n_row [MAX_PIECES];
    logic [AW-1:0]      r_cnt;
    logic               r_done;

    always_comb begin
        for (int k = 0; k < MAX_PIECES; k++) begin
            if (k == 0) begin
                n_row[k] = r_row[k] + BINOM_W'(1);
            end else begin
                n_row[k] = r_row[k] + r_row[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
            for (int k = 0; k < MAX_PIECES; k++) begin
                r_row[k] <= '0;
            end
        end else if (!r_done) begin
            r_row <= n_row;
            if (r_cnt == AW'(MAX_SQUARES)) begin
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + AW'(1);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < MAX_PIECES; k++) begin
            o_wdata[k*BINOM_W +: BINOM_W] = r_row[k];
        end
    end

    assign o_waddr         = r_cnt;
    assign o_status.wr_en  = !r_done;
    assign o_status.done   = r_done;

endmodule

// File: rtl/position_combinadic_unrank.sv
`timescale 1ns / 1ps

// channel   | direction | ports                                         | handshake
// ----------+-----------+-----------------------------------------------+---------------------
// request   | in        | i_table_index                                 | i_start & !o_busy
// result    | out       | o_square o_piece_code o_black_to_move         | o_valid, one cycle
//           |           | o_index_invalid o_last                        |
// config    | in        | i_cfg_addr i_cfg_data                         | i_cfg_we, any cycle
//
// after reset a fill sweep writes Pascal's triangle into the binomial ram,
//   one row per cycle, MAX_SQUARES+1 rows; o_busy stays high until the fill is done
// a request holds o_busy through one check state, the search state (which walks
//   down from square n-1 until all p pieces are placed) and the emit state, which
//   gives one result per piece; the single read port of the binomial ram gives
//   one C(x,i) per cycle; the last result comes in the cycle that busy drops
// an out-of-range request gives its single result from the check state
// results are strobed for one cycle; the receiver cannot stall the block

module position_combinadic_unrank #(
    parameter int MAX_PIECES  = 8,
    parameter int MAX_SQUARES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [pcu_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [pcu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request
    input  logic                            i_start,
    input  logic [pcu_pkg::INDEX_W-1:0]     i_table_index,
    output logic                            o_busy,
    // results
    output logic                            o_valid,
    output logic [pcu_pkg::SQ_W-1:0]        o_square,
    output logic [pcu_pkg::CODE_W-1:0]      o_piece_code,
    output logic                            o_black_to_move,
    output logic                            o_index_invalid,
    output logic                            o_last
);

    import pcu_pkg::*;

    localparam int AW    = $clog2(MAX_SQUARES + 1);
    localparam int PW    = $clog2(MAX_PIECES + 1);
    localparam int SI_W  = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int ROW_W = MAX_PIECES * BINOM_W;
    localparam int TC_W  = 2 * MAX_PIECES;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_EMIT
    } t_state;

    // configuration registers
    logic [SQC_W-1:0] r_square_count;
    logic [PCC_W-1:0] r_piece_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_count <= SQUARE_COUNT_RST;
            r_piece_count  <= PIECE_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SQUARE_COUNT: r_square_count <= i_cfg_data[SQC_W-1:0];
                CFG_PIECE_COUNT:  r_piece_count  <= i_cfg_data[PCC_W-1:0];
                default:          ;
            endcase
        end
    end

    // clamped counts, as seen at accept time
    logic [AW-1:0] w_n_sat;
    logic [PW-1:0] w_p_sat;

    always_comb begin
        if (r_square_count > SQC_W'(MAX_SQUARES)) begin
            w_n_sat = AW'(MAX_SQUARES);
        end else begin
            w_n_sat = r_square_count[AW-1:0];
        end
        if (r_piece_count == '0) begin
            w_p_sat = PW'(1);
        end else if (r_piece_count > PCC_W'(MAX_PIECES)) begin
            w_p_sat = PW'(MAX_PIECES);
        end else begin
            w_p_sat = r_piece_count[PW-1:0];
        end
    end

    // binomial table: row x holds C(x,1..MAX_PIECES)
    t_fill_status          w_fill;
    logic [AW-1:0]         w_fill_addr;
    logic [ROW_W-1:0]      w_fill_data;
    logic [AW-1:0]         w_raddr;
    logic [ROW_W-1:0]      w_rdata;

    pcu_pascal_fill #(
        .MAX_PIECES  (MAX_PIECES),
        .MAX_SQUARES (MAX_SQUARES)
    ) u_fill (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_status (w_fill),
        .o_waddr  (w_fill_addr),
        .o_wdata  (w_fill_data)
    );

    pcu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SQUARES + 1)
    ) u_binom_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill.wr_en),
        .i_waddr (w_fill_addr),
        .i_wdata (w_fill_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // sequencer state
    t_state                r_state;
    logic [INDEX_W-1:0]    r_idx;
    logic [AW-1:0]         r_n;
    logic [PW-1:0]         r_p;
    logic [PW-1:0]         r_i;        // piece being placed, p down to 1
    logic [PW-1:0]         r_j;        // result being emitted
    logic [BINOM_W-1:0]    r_rank;
    logic [TC_W-1:0]       r_tcode;
    logic [AW-1:0]         r_iss;      // square whose row is read this cycle
    logic [AW-1:0]         r_pend_x;   // square whose row is on w_rdata
    logic                  r_pend_v;
    logic [SQ_W-1:0]       r_sq [MAX_PIECES];

    logic                  r_valid;
    logic [SQ_W-1:0]       r_square;
    logic [CODE_W-1:0]     r_piece_code;
    logic                  r_black;
    logic                  r_oor;
    logic                  r_last;

    wire w_accept = i_start && (r_state == S_IDLE);

    // the read address is the clamped square count when a request comes in,
    // the search pointer otherwise
    assign w_raddr = (r_state == S_IDLE) ? w_n_sat : r_iss;

    // pick C(x,k) out of the row, k = p while checking, i while searching
    logic [PW-1:0]      w_col_sel;
    logic [BINOM_W-1:0] w_col;

    always_comb begin
        w_col_sel = (r_state == S_CHECK) ? r_p : r_i;
        w_col     = '0;
        for (int k = 1; k <= MAX_PIECES; k++) begin
            if (w_col_sel == PW'(k)) begin
                w_col = w_rdata[(k-1)*BINOM_W +: BINOM_W];
            end
        end
    end

    // entry count C(n,p) * 4^p * 2; the shift 2p+1 also drops bit 0 and
    // the type code from the index to leave the rank
    logic [PW:0]          w_sh;
    logic [INDEX_W-1:0]   w_entries;
    logic                 w_oor;
    logic [INDEX_W-1:0]   w_rank_full;
    logic                 w_hit;
    logic                 w_last_j;

    assign w_sh        = {r_p, 1'b1};
    assign w_entries   = INDEX_W'(w_col) << w_sh;
    assign w_oor       = (r_idx >= w_entries);
    assign w_rank_full = r_idx >> w_sh;
    // C(x,i) fits the rank; at x = 0 the entry is zero, so the search
    // always stops there
    assign w_hit       = r_pend_v && (w_col <= r_rank);
    assign w_last_j    = ((r_j + PW'(1)) == r_p);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_pend_v <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    if (w_fill.done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= i_table_index;
                        r_n     <= w_n_sat;
                        r_p     <= w_p_sat;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // row n is on the read data now
                    if (w_oor) begin
                        r_valid      <= 1'b1;
                        r_square     <= '0;
                        r_piece_code <= '0;
                        r_black      <= 1'b0;
                        r_oor        <= 1'b1;
                        r_last       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_rank   <= w_rank_full[BINOM_W-1:0];
                        r_tcode  <= r_idx[TC_W:1];
                        r_i      <= r_p;
                        r_iss    <= r_n - AW'(1);
                        r_pend_v <= 1'b0;
                        r_state  <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (w_hit) begin
                        // place piece i, drop the read already in flight
                        r_sq[SI_W'(r_i - PW'(1))] <= SQ_W'(r_pend_x);
                        r_rank   <= r_rank - w_col;
                        r_i      <= r_i - PW'(1);
                        r_pend_v <= 1'b0;
                        r_iss    <= (r_pend_x == '0) ? '0 : r_pend_x - AW'(1);
                        if (r_i == PW'(1)) begin
                            r_j     <= '0;
                            r_state <= S_EMIT;
                        end
                    end else begin
                        // keep streaming reads down the squares
                        r_pend_v <= 1'b1;
                        r_pend_x <= r_iss;
                        r_iss    <= (r_iss == '0) ? '0 : r_iss - AW'(1);
                    end
                end
                S_EMIT: begin
                    r_valid      <= 1'b1;
                    r_square     <= r_sq[SI_W'(r_j)];
                    r_piece_code <= r_tcode[2*r_j +: 2];
                    r_black      <= r_idx[0];
                    r_oor        <= 1'b0;
                    r_last       <= w_last_j;
                    r_j          <= r_j + PW'(1);
                    if (w_last_j) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_square        = r_square;
    assign o_piece_code    = r_piece_code;
    assign o_black_to_move = r_black;
    assign o_index_invalid = r_oor;
    assign o_last          = r_last;

endmodule

// File: rtl/pcu_checker.sv
`timescale 1ns / 1ps

module pcu_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            o_busy,
    input  logic                            o_valid,
    input  logic [pcu_pkg::SQ_W-1:0]        o_square,
    input  logic [pcu_pkg::CODE_W-1:0]      o_piece_code,
    input  logic                            o_black_to_move,
    input  logic                            o_index_invalid,
    input  logic                            o_last
);

    // an out-of-range result is a single, cleared result
    a_oor_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_invalid |->
            o_last && (o_square == '0) && (o_piece_code == '0) && !o_black_to_move)
        else $error("out-of-range result not alone or not cleared");

    // piece results of one request come in consecutive cycles
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("gap inside a result burst");

    // nothing follows the last result of a request directly
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result right after last");

    // no result, and busy high, in the cycle after a request is taken
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> !o_valid && o_busy)
        else $error("result too early after request");

endmodule

bind position_combinadic_unrank pcu_checker u_pcu_checker (.*);
